// ----- design/assert_macros.svh -----
// assertion macros used by the smoother design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_HOLDS(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/hrfir_pkg.sv -----
// types and constants for the centered fir heart-rate smoother
package hrfir_pkg;

    localparam int MAX_TAPS_DEF = 7;
    localparam int NUM_COEF     = 7;
    localparam int COEF_W       = 16;
    localparam int SAMPLE_W     = 8;
    localparam int RESULT_W     = 16;
    localparam int TAP_W        = 3;
    localparam int CFG_INDEX_W  = 4;
    localparam int CFG_DATA_W   = 16;
    localparam int UNITY_Q14    = 16384;
    localparam int RND_SHIFT    = 6;
    localparam int RND_HALF     = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_TAP_COUNT  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COEF_FIRST = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COEF_LAST  = 4'd7;

    localparam logic [TAP_W-1:0]  TAP_COUNT_RST = 3'd1;
    localparam logic [COEF_W-1:0] COEF_0_RST    = 16'd16384;

    typedef struct packed {
        logic [SAMPLE_W-1:0] hr_sample;
        logic                last_sample;
    } hr_sample_t;

    typedef struct packed {
        logic [RESULT_W-1:0] filtered_hr;
        logic                was_filtered;
        logic                config_error;
        logic                last_result;
    } hr_result_t;

endpackage

// ----- design/hr_centered_fir_smoother.sv -----
// centered fir smoother for heart-rate samples with a single shared multiply-accumulate unit
//
//  channel  | signals                              | transfer when
//  ---------+--------------------------------------+------------------------------
//  sample   | sample_valid, sample_ready, sample   | sample_valid && sample_ready
//  result   | result_valid, result_ready, result   | result_valid && result_ready
//  cfg      | cfg_valid, cfg_ready, cfg_index/data | cfg_valid && cfg_ready
//
// each sample passes through the multiply-accumulate loop, a drain step and evaluation,
// then emits its results (up to four) one at a time and takes a closing step
// with a bad tap count the loop is skipped and the sample goes straight to evaluation
// the single 16x9 multiplier is stepped once per tap
// reset clears the sample line, the stream count and the registers to their defaults
// a stalled result holds the output register; the next sample is taken once its results are queued
`include "assert_macros.svh"

module hr_centered_fir_smoother
    import hrfir_pkg::*;
#(
    parameter int MAX_TAPS = MAX_TAPS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    output logic                   sample_ready,
    input  hr_sample_t             sample,
    output logic                   result_valid,
    input  logic                   result_ready,
    output hr_result_t             result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int IDX_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int PROD_W = COEF_W + SAMPLE_W + 1;
    localparam int ACC_W  = PROD_W + 3;
    localparam int SUM_W  = COEF_W + 3;
    localparam int CNT_W  = TAP_W + 1;
    localparam int HALF_W = TAP_W - 1;
    localparam int KIDX_W = $clog2(NUM_COEF);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_EVAL,
        S_EMIT
    } state_t;

    state_t                    state_reg;
    logic [TAP_W-1:0]          t_reg;
    logic signed [COEF_W-1:0]  coef_reg [NUM_COEF];
    logic [SAMPLE_W-1:0]       line_reg [MAX_TAPS];
    logic [TAP_W-1:0]          seen_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      last_reg;
    logic [KIDX_W-1:0]         k_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      prod_vld_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic                      err_reg;
    logic                      filt_reg;
    logic                      main_reg;
    logic [RESULT_W-1:0]       main_val_reg;
    logic [HALF_W-1:0]         pend_reg;
    logic                      out_valid_reg;
    hr_result_t                out_reg;

    logic                      t_ok;
    logic                      err_now;
    logic [HALF_W-1:0]         half_now;
    logic                      filt_now;
    logic                      main_now;
    logic [HALF_W-1:0]         pend_now;
    logic [CNT_W-1:0]          rd_pos;
    logic [SAMPLE_W-1:0]       rd_sample;
    logic signed [COEF_W-1:0]  coef_k;
    logic signed [PROD_W-1:0]  prod_next;
    logic [ACC_W-1:0]          acc_rnd;
    logic [RESULT_W-1:0]       fir_val;
    logic [RESULT_W-1:0]       main_val_now;
    logic [RESULT_W-1:0]       pass_val;
    logic                      slot_free;
    logic                      emit_now;

    assign t_ok     = t_reg[0] && (int'(t_reg) <= MAX_TAPS);
    assign err_now  = !t_ok || (sum_reg != SUM_W'(UNITY_Q14));
    assign half_now = err_now ? '0 : t_reg[TAP_W-1:1];
    assign filt_now = !err_now && (cnt_reg >= {1'b0, t_reg});
    assign main_now = cnt_reg > CNT_W'(half_now);
    assign pend_now = !last_reg ? '0 :
                      (cnt_reg < CNT_W'(half_now)) ? HALF_W'(cnt_reg) : half_now;

    // one line read port shared by the loop, the centered pass value and the flush
    always_comb
    begin
        case (state_reg)
            S_MAC:   rd_pos = {1'b0, t_reg} - CNT_W'(1) - CNT_W'(k_reg);
            S_EVAL:  rd_pos = CNT_W'(half_now);
            S_EMIT:  rd_pos = CNT_W'(pend_reg) - CNT_W'(1);
            default: rd_pos = '0;
        endcase
    end

    assign rd_sample = (int'(rd_pos) < MAX_TAPS) ? line_reg[IDX_W'(rd_pos)] : '0;
    assign pass_val  = {rd_sample, 8'h00};

    assign coef_k    = coef_reg[k_reg];
    assign prod_next = coef_k * $signed({1'b0, rd_sample});

    // round half up to q8.8, clamp below at zero and above at full scale
    assign acc_rnd = acc_reg + ACC_W'(RND_HALF);
    always_comb
    begin
        if (acc_reg[ACC_W-1])
            fir_val = '0;
        else if (|acc_rnd[ACC_W-1:RND_SHIFT+RESULT_W])
            fir_val = '1;
        else
            fir_val = acc_rnd[RND_SHIFT+RESULT_W-1:RND_SHIFT];
    end

    assign main_val_now = filt_now ? fir_val : pass_val;
    assign slot_free    = !out_valid_reg || result_ready;
    assign emit_now     = (state_reg == S_EMIT) && (main_reg || (pend_reg != '0)) && slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            t_reg         <= TAP_COUNT_RST;
            for (int i = 0; i < NUM_COEF; i++)
            begin
                coef_reg[i] <= (i == 0) ? COEF_0_RST : '0;
            end
            for (int i = 0; i < MAX_TAPS; i++)
            begin
                line_reg[i] <= '0;
            end
            seen_reg      <= '0;
            cnt_reg       <= '0;
            last_reg      <= 1'b0;
            k_reg         <= '0;
            prod_reg      <= '0;
            prod_vld_reg  <= 1'b0;
            acc_reg       <= '0;
            sum_reg       <= '0;
            err_reg       <= 1'b0;
            filt_reg      <= 1'b0;
            main_reg      <= 1'b0;
            main_val_reg  <= '0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (emit_now)
                out_valid_reg <= 1'b1;
            else if (result_valid && result_ready)
                out_valid_reg <= 1'b0;

            if (cfg_valid)
            begin
                if (cfg_index == CFG_TAP_COUNT)
                    t_reg <= cfg_data[TAP_W-1:0];
                else if (cfg_index >= CFG_COEF_FIRST && cfg_index <= CFG_COEF_LAST)
                    coef_reg[KIDX_W'(cfg_index - CFG_COEF_FIRST)] <= cfg_data;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (sample_valid)
                    begin
                        for (int i = MAX_TAPS - 1; i > 0; i--)
                        begin
                            line_reg[i] <= line_reg[i-1];
                        end
                        line_reg[0]  <= sample.hr_sample;
                        last_reg     <= sample.last_sample;
                        cnt_reg      <= {1'b0, seen_reg} + CNT_W'(1);
                        k_reg        <= '0;
                        sum_reg      <= '0;
                        acc_reg      <= '0;
                        prod_vld_reg <= 1'b0;
                        state_reg    <= t_ok ? S_MAC : S_EVAL;
                    end
                end
                S_MAC:
                begin
                    prod_reg     <= prod_next;
                    prod_vld_reg <= 1'b1;
                    sum_reg      <= sum_reg + SUM_W'(coef_k);
                    if (prod_vld_reg)
                        acc_reg <= acc_reg + ACC_W'(prod_reg);
                    k_reg <= k_reg + KIDX_W'(1);
                    if (TAP_W'(k_reg) == t_reg - TAP_W'(1))
                        state_reg <= S_DRAIN;
                end
                S_DRAIN:
                begin
                    acc_reg   <= acc_reg + ACC_W'(prod_reg);
                    state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    err_reg      <= err_now;
                    filt_reg     <= filt_now;
                    main_reg     <= main_now;
                    main_val_reg <= main_val_now;
                    pend_reg     <= pend_now;
                    state_reg    <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (main_reg)
                    begin
                        if (slot_free)
                        begin
                            out_reg.filtered_hr  <= main_val_reg;
                            out_reg.was_filtered <= filt_reg;
                            out_reg.config_error <= err_reg;
                            out_reg.last_result  <= last_reg && (pend_reg == '0);
                            main_reg             <= 1'b0;
                        end
                    end
                    else if (pend_reg != '0)
                    begin
                        if (slot_free)
                        begin
                            out_reg.filtered_hr  <= pass_val;
                            out_reg.was_filtered <= 1'b0;
                            out_reg.config_error <= err_reg;
                            out_reg.last_result  <= last_reg && (pend_reg == HALF_W'(1));
                            pend_reg             <= pend_reg - HALF_W'(1);
                        end
                    end
                    else
                    begin
                        // end of stream clears the window
                        if (last_reg)
                        begin
                            for (int i = 0; i < MAX_TAPS; i++)
                            begin
                                line_reg[i] <= '0;
                            end
                            seen_reg <= '0;
                        end
                        else
                        begin
                            seen_reg <= cnt_reg[CNT_W-1] ? '1 : cnt_reg[TAP_W-1:0];
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign sample_ready = (state_reg == S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    `ASSERT_HOLDS(a_idle_nothing_queued, sample_ready, !main_reg && (pend_reg == '0))
    `ASSERT_HOLDS(a_filtered_not_error, result_valid && result.was_filtered, !result.config_error)
    `ASSERT_NEXT(a_mac_exits_to_drain, state_reg == S_MAC, state_reg == S_MAC || state_reg == S_DRAIN)

endmodule

// ----- tb/sv/tb_hr_centered_fir_smoother.sv -----
// testbench for the centered fir heart-rate smoother: directed table, then random streams
`timescale 1ns / 1ps

module tb_hr_centered_fir_smoother;
    import hrfir_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_WAIT  = 40;
    localparam int ROUND_ITEMS  = 62;
    localparam int PRINT_CAP    = 50;

    typedef enum logic [1:0] {
        ROW_REG,
        ROW_TYPED,
        ROW_PRED
    } row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        hr_sample_t             smp;
        hr_result_t             want;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   sample_valid = 1'b0;
    logic                   sample_ready;
    hr_sample_t             sample = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    hr_result_t             result;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // predictor state
    logic [SAMPLE_W-1:0]      hr_line [MAX_TAPS_DEF];
    logic [2:0]               stream_count;
    logic [TAP_W-1:0]         taps;
    logic signed [COEF_W-1:0] coefs [NUM_COEF];

    hr_result_t step_out [$];
    hr_result_t pending_results [$];
    hr_result_t oldest;
    stim_row_t  plan [$];

    int err_count = 0;
    int cycle_count = 0;
    int src_idle = 0;
    int sink_stall = 0;

    hr_centered_fir_smoother u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_hr_centered_fir_smoother failed");
            $finish;
        end
    end

    task automatic note_mismatch(input string what, input int got, input int want);
        if (err_count < PRINT_CAP)
            $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
        err_count++;
    endtask

    // result side: compare each transfer, then pick the next ready
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
                note_mismatch("result with none expected, filtered_hr", result.filtered_hr, 0);
            else
            begin
                oldest = pending_results.pop_front();
                if (result.filtered_hr !== oldest.filtered_hr)
                    note_mismatch("filtered_hr", result.filtered_hr, oldest.filtered_hr);
                if (result.was_filtered !== oldest.was_filtered)
                    note_mismatch("was_filtered", result.was_filtered, oldest.was_filtered);
                if (result.config_error !== oldest.config_error)
                    note_mismatch("config_error", result.config_error, oldest.config_error);
                if (result.last_result !== oldest.last_result)
                    note_mismatch("last_result", result.last_result, oldest.last_result);
            end
        end
        result_ready <= (int'($urandom_range(99)) >= sink_stall);
    end

    function automatic void smoother_reset();
        foreach (hr_line[i])
            hr_line[i] = '0;
        stream_count = '0;
        taps = TAP_COUNT_RST;
        foreach (coefs[k])
            coefs[k] = '0;
        coefs[0] = COEF_0_RST;
    endfunction

    function automatic void smooth_step(input hr_sample_t s);
        bit         bad;
        int         t;
        int         half;
        int         cnt;
        int         pend;
        longint     acc;
        longint     sum;
        hr_result_t r;
        step_out.delete();
        t = int'(taps);
        sum = 0;
        for (int k = 0; k < t; k++)
            sum += longint'(coefs[k]);
        bad = (t % 2 == 0) || (t > MAX_TAPS_DEF) || (sum != UNITY_Q14);
        half = bad ? 0 : t / 2;
        cnt = int'(stream_count) + 1;
        for (int i = MAX_TAPS_DEF - 1; i > 0; i--)
            hr_line[i] = hr_line[i-1];
        hr_line[0] = s.hr_sample;
        if (cnt > half)
        begin
            r.was_filtered = !bad && (cnt >= t);
            r.config_error = bad;
            r.last_result = 1'b0;
            if (r.was_filtered)
            begin
                acc = 0;
                for (int k = 0; k < t; k++)
                    acc += longint'(coefs[k]) * longint'({1'b0, hr_line[t-1-k]});
                if (acc < 0)
                    acc = 0;
                else
                    acc = (acc + RND_HALF) >>> RND_SHIFT;
                if (acc > 65535)
                    acc = 65535;
                r.filtered_hr = acc[RESULT_W-1:0];
            end
            else
                r.filtered_hr = {hr_line[half], 8'h00};
            step_out.push_back(r);
        end
        if (s.last_sample)
        begin
            pend = (cnt < half) ? cnt : half;
            while (pend > 0)
            begin
                pend--;
                r.filtered_hr = {hr_line[pend], 8'h00};
                r.was_filtered = 1'b0;
                r.config_error = bad;
                r.last_result = 1'b0;
                step_out.push_back(r);
            end
            if (step_out.size() > 0)
                step_out[$].last_result = 1'b1;
            stream_count = '0;
            foreach (hr_line[i])
                hr_line[i] = '0;
        end
        else
            stream_count = (cnt > 7) ? 3'd7 : cnt[2:0];
    endfunction

    // cfg_valid stays high after the transfer; the caller lowers it after the last write
    task automatic load_register(input logic [CFG_INDEX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_TAP_COUNT)
            taps = val[TAP_W-1:0];
        else if (idx >= CFG_COEF_FIRST && idx <= CFG_COEF_LAST)
            coefs[idx - CFG_COEF_FIRST] = val;
    endtask

    // sample_valid stays high after the transfer; the caller lowers it at the end of a run
    task automatic offer_sample(input hr_sample_t s, input bit typed, input hr_result_t want);
        while (int'($urandom_range(99)) < src_idle)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample <= s;
        do
            @(posedge clk);
        while (!sample_ready);
        smooth_step(s);
        if (typed)
            pending_results.push_back(want);
        else
            foreach (step_out[i])
                pending_results.push_back(step_out[i]);
    endtask

    task automatic settle_block();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic random_config();
        int                    coef_v [NUM_COEF];
        int                    t;
        int                    mode;
        int                    span;
        int                    total;
        int                    mid;
        bit                    fits;
        logic [CFG_DATA_W-1:0] d;
        mode = $urandom_range(9);
        if (mode == 0)
            t = 2 * $urandom_range(3);
        else
            t = 2 * $urandom_range(3) + 1;
        span = (mode == 2) ? 32767 : 6000;
        fits = 1'b0;
        while (!fits)
        begin
            for (int k = 0; k < NUM_COEF; k++)
                if (mode < 2)
                    coef_v[k] = int'($urandom_range(65535)) - 32768;
                else
                    coef_v[k] = int'($urandom_range(2 * span)) - span;
            if (mode < 2)
                fits = 1'b1;
            else
            begin
                mid = t / 2;
                total = 0;
                for (int k = 0; k < t; k++)
                    if (k != mid)
                        total += coef_v[k];
                coef_v[mid] = UNITY_Q14 - total;
                fits = (coef_v[mid] >= -32768) && (coef_v[mid] <= 32767);
            end
        end
        d = $urandom;
        d[TAP_W-1:0] = t[TAP_W-1:0];
        load_register(CFG_TAP_COUNT, d);
        for (int k = 0; k < NUM_COEF; k++)
            load_register(CFG_INDEX_W'(CFG_COEF_FIRST + k), coef_v[k][CFG_DATA_W-1:0]);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        stim_row_t row;
        row.kind = ROW_REG;
        row.reg_idx = idx;
        row.reg_val = val;
        row.smp = '0;
        row.want = '0;
        plan.push_back(row);
    endtask

    task automatic add_typed(input logic [7:0] hr, input logic lst, input logic [15:0] fhr,
                             input logic filt, input logic err, input logic lres);
        stim_row_t row;
        row.kind = ROW_TYPED;
        row.reg_idx = '0;
        row.reg_val = '0;
        row.smp = '{hr_sample: hr, last_sample: lst};
        row.want = '{filtered_hr: fhr, was_filtered: filt, config_error: err,
                     last_result: lres};
        plan.push_back(row);
    endtask

    task automatic add_pred(input logic [7:0] hr, input logic lst);
        stim_row_t row;
        row.kind = ROW_PRED;
        row.reg_idx = '0;
        row.reg_val = '0;
        row.smp = '{hr_sample: hr, last_sample: lst};
        row.want = '0;
        plan.push_back(row);
    endtask

    initial
    begin
        int         src_pct [4];
        int         sink_pct [4];
        int         left;
        int         len;
        hr_sample_t s;
        src_pct = '{0, 51, 0, 27};
        sink_pct = '{0, 0, 51, 27};
        smoother_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // writes to unused indexes must leave the defaults alone
        add_reg(CFG_COEF_LAST + 4'd1, 16'hFFFF);
        add_reg({CFG_INDEX_W{1'b1}}, 16'hFFFF);
        add_typed(8'd0,   1'b0, 16'h0000, 1'b1, 1'b0, 1'b0);
        add_typed(8'd255, 1'b0, 16'hFF00, 1'b1, 1'b0, 1'b0);
        add_typed(8'hAA,  1'b0, 16'hAA00, 1'b1, 1'b0, 1'b0);
        add_typed(8'h55,  1'b1, 16'h5500, 1'b1, 1'b0, 1'b1);
        // even window length
        add_reg(CFG_TAP_COUNT, 16'd2);
        add_typed(8'h81,  1'b0, 16'h8100, 1'b0, 1'b1, 1'b0);
        add_typed(8'h7E,  1'b1, 16'h7E00, 1'b0, 1'b1, 1'b1);
        // weights off by one from unity
        add_reg(CFG_TAP_COUNT, 16'd3);
        add_reg(CFG_COEF_FIRST + 4'd1, 16'd1);
        add_typed(8'h12,  1'b1, 16'h1200, 1'b0, 1'b1, 1'b1);
        // three taps, short stream, then a window change mid-stream
        add_reg(CFG_COEF_FIRST, 16'd4096);
        add_reg(CFG_COEF_FIRST + 4'd1, 16'd8192);
        add_reg(CFG_COEF_FIRST + 4'd2, 16'd4096);
        add_pred(8'd10, 1'b1);
        add_pred(8'd20, 1'b0);
        add_pred(8'd30, 1'b0);
        add_reg(CFG_TAP_COUNT, 16'd5);
        add_pred(8'd40, 1'b0);
        add_pred(8'd50, 1'b1);
        // seven taps at the coefficient extremes: saturation, negative sum, full flush
        add_reg(CFG_TAP_COUNT, 16'd7);
        add_reg(CFG_COEF_FIRST,        16'h8000);
        add_reg(CFG_COEF_FIRST + 4'd1, 16'h7FFF);
        add_reg(CFG_COEF_FIRST + 4'd2, 16'h8000);
        add_reg(CFG_COEF_FIRST + 4'd3, 16'h7FFF);
        add_reg(CFG_COEF_FIRST + 4'd4, 16'd16386);
        add_reg(CFG_COEF_FIRST + 4'd5, 16'd0);
        add_reg(CFG_COEF_FIRST + 4'd6, 16'd0);
        add_pred(8'd0,   1'b0);
        add_pred(8'd255, 1'b0);
        add_pred(8'd0,   1'b0);
        add_pred(8'd255, 1'b0);
        add_pred(8'd255, 1'b0);
        add_pred(8'd0,   1'b0);
        add_pred(8'd0,   1'b0);
        add_pred(8'd255, 1'b0);
        add_pred(8'd0,   1'b0);
        add_pred(8'd255, 1'b1);

        for (int i = 0; i < plan.size(); i++)
        begin
            if (plan[i].kind == ROW_REG)
            begin
                if (i == 0 || plan[i-1].kind != ROW_REG)
                    settle_block();
                load_register(plan[i].reg_idx, plan[i].reg_val);
                if (i == plan.size() - 1 || plan[i+1].kind != ROW_REG)
                    cfg_valid <= 1'b0;
            end
            else
            begin
                offer_sample(plan[i].smp, plan[i].kind == ROW_TYPED, plan[i].want);
                if (i == plan.size() - 1 || plan[i+1].kind == ROW_REG)
                    sample_valid <= 1'b0;
            end
        end

        // random streams, two settings per idling phase
        for (int ph = 0; ph < 4; ph++)
        begin
            for (int rnd = 0; rnd < 2; rnd++)
            begin
                settle_block();
                src_idle = src_pct[ph];
                sink_stall = sink_pct[ph];
                random_config();
                left = ROUND_ITEMS;
                while (left > 0)
                begin
                    if ($urandom_range(4) == 0)
                        len = $urandom_range(1, 3);
                    else
                        len = $urandom_range(4, 20);
                    for (int j = 0; j < len && left > 0; j++)
                    begin
                        if ($urandom_range(9) == 0)
                            s.hr_sample = $urandom_range(1) ? 8'hFF : 8'h00;
                        else
                            s.hr_sample = $urandom_range(255);
                        // now and then a stream runs on without its end mark
                        s.last_sample = (j == len - 1) && ($urandom_range(9) != 0);
                        offer_sample(s, 1'b0, '0);
                        left--;
                    end
                end
                sample_valid <= 1'b0;
            end
        end

        settle_block();
        if (err_count == 0)
            $display("tb_hr_centered_fir_smoother passed");
        else
            $display("tb_hr_centered_fir_smoother failed");
        $finish;
    end

endmodule
